// ----- rtl/core/lwc_pkg.sv -----
// Shared types, constants and helpers for the lagged window correlation block.
// No dependencies; every other file of the block depends on this package.
package lwc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int WIN_W      = 7;
	localparam int LAGCFG_W   = 6;
	localparam int LAG_W      = 5;
	localparam int STR_W      = 8;
	localparam int FILL_W     = 8;
	localparam int NUM_CELLS  = 32;
	localparam int WIN_MIN    = 2;
	localparam int WIN_MAX    = 64;
	localparam int LAG_MIN    = 1;
	localparam int LAG_MAX    = 32;
	localparam int WIN_RESET  = 40;
	localparam int LAG_RESET  = 20;
	localparam int FILL_MAX   = 255;
	localparam int HISTORY_DEPTH_DEF = 128;

	// Sum widths: window sums, sums of products, n-scaled variances.
	localparam int SUM_W  = 22;
	localparam int SQ_W   = 38;
	localparam int VAR_W  = 44;
	localparam int HALF_W = VAR_W / 2;
	localparam int PROD_W = 2 * VAR_W;
	localparam int NUM_W  = PROD_W + STR_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG     = 2'd1;

	// One history sample pair with its age, as it travels along the cell row.
	typedef struct packed {
		logic                valid;
		logic [WIN_W-1:0]    idx;
		logic [SAMPLE_W-1:0] f;
		logic [SAMPLE_W-1:0] g;
	} lwc_tap_t;

	// Running sums of one window pair.
	typedef struct packed {
		logic [SUM_W-1:0] sf;
		logic [SUM_W-1:0] sg;
		logic [SQ_W-1:0]  sfg;
		logic [SQ_W-1:0]  sff;
		logic [SQ_W-1:0]  sgg;
	} lwc_sums_t;

	// Request to the ratio unit.
	typedef struct packed {
		logic             start;
		logic [WIN_W-1:0] n;
		lwc_sums_t        sums;
	} lwc_job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_STREAM, ST_DRAIN, ST_CALC_A, ST_CALC_B, ST_EMIT
	} lwc_state_t;

	typedef enum logic [2:0] {
		RS_IDLE, RS_MUL, RS_SUB, RS_PART, RS_SCALE, RS_DIV, RS_DONE
	} lwc_rstate_t;

	function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
		if (v < WIN_W'(WIN_MIN)) return WIN_W'(WIN_MIN);
		if (v > WIN_W'(WIN_MAX)) return WIN_W'(WIN_MAX);
		return v;
	endfunction

	function automatic logic [LAGCFG_W-1:0] clamp_lag(input logic [LAGCFG_W-1:0] v);
		if (v < LAGCFG_W'(LAG_MIN)) return LAGCFG_W'(LAG_MIN);
		if (v > LAGCFG_W'(LAG_MAX)) return LAGCFG_W'(LAG_MAX);
		return v;
	endfunction

endpackage

// ----- rtl/core/lwc_if.sv -----
// Handshake channels of the lagged window correlation block.
// Depends on lwc_pkg for field widths.
interface lwc_in_if;
	logic                         valid;
	logic                         ready;
	logic [lwc_pkg::SAMPLE_W-1:0] f_sample;
	logic [lwc_pkg::SAMPLE_W-1:0] g_sample;
	modport source (output valid, f_sample, g_sample, input ready);
	modport sink (input valid, f_sample, g_sample, output ready);
endinterface

interface lwc_out_if;
	logic                      valid;
	logic                      ready;
	logic [lwc_pkg::LAG_W-1:0] lag;
	logic [lwc_pkg::STR_W-1:0] f_delayed_strength;
	logic [lwc_pkg::STR_W-1:0] g_delayed_strength;
	logic                      last;
	modport source (output valid, lag, f_delayed_strength, g_delayed_strength, last,
		input ready);
	modport sink (input valid, lag, f_delayed_strength, g_delayed_strength, last,
		output ready);
endinterface

interface lwc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lwc_pkg::CFG_IDX_W-1:0]  index;
	logic [lwc_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lwc_cell.sv -----
// One cell of the lag row: passes the sample stream on through one delay register and
// accumulates the window sums of both lag directions. Depends on lwc_pkg.
module lwc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic [lwc_pkg::WIN_W-1:0] win,
	input  lwc_pkg::lwc_tap_t         bcast,
	input  lwc_pkg::lwc_tap_t         chain_in,
	output lwc_pkg::lwc_tap_t         chain_out,
	output lwc_pkg::lwc_sums_t        sums_a,
	output lwc_pkg::lwc_sums_t        sums_b
);
	import lwc_pkg::*;

	lwc_tap_t            chain_q;
	lwc_sums_t           acc_a_q, acc_b_q;
	logic                hit;
	logic [2*SAMPLE_W-1:0] pa_fg, pa_ff, pa_gg, pb_fg, pb_ff, pb_gg;

	// The delayed stream element pairs with the newest-first broadcast element.
	assign hit = bcast.valid && chain_in.valid && (chain_in.idx < win);

	// Set A: f broadcast, g delayed. Set B: f delayed, g broadcast.
	always_comb begin
		pa_fg = {16'b0, bcast.f} * {16'b0, chain_in.g};
		pa_ff = {16'b0, bcast.f} * {16'b0, bcast.f};
		pa_gg = {16'b0, chain_in.g} * {16'b0, chain_in.g};
		pb_fg = {16'b0, chain_in.f} * {16'b0, bcast.g};
		pb_ff = {16'b0, chain_in.f} * {16'b0, chain_in.f};
		pb_gg = {16'b0, bcast.g} * {16'b0, bcast.g};
	end

	// Delay register that hands the stream to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q.valid <= 1'b0;
		end else begin
			chain_q.valid <= chain_in.valid;
			chain_q.idx   <= chain_in.idx;
			chain_q.f     <= chain_in.f;
			chain_q.g     <= chain_in.g;
		end
	end

	// Window accumulators, cleared at the start of each item.
	always_ff @(posedge clk) begin
		if (clr) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (hit) begin
			acc_a_q.sf  <= acc_a_q.sf + SUM_W'(bcast.f);
			acc_a_q.sg  <= acc_a_q.sg + SUM_W'(chain_in.g);
			acc_a_q.sfg <= acc_a_q.sfg + SQ_W'(pa_fg);
			acc_a_q.sff <= acc_a_q.sff + SQ_W'(pa_ff);
			acc_a_q.sgg <= acc_a_q.sgg + SQ_W'(pa_gg);
			acc_b_q.sf  <= acc_b_q.sf + SUM_W'(chain_in.f);
			acc_b_q.sg  <= acc_b_q.sg + SUM_W'(bcast.g);
			acc_b_q.sfg <= acc_b_q.sfg + SQ_W'(pb_fg);
			acc_b_q.sff <= acc_b_q.sff + SQ_W'(pb_ff);
			acc_b_q.sgg <= acc_b_q.sgg + SQ_W'(pb_gg);
		end
	end

	assign chain_out = chain_q;
	assign sums_a    = acc_a_q;
	assign sums_b    = acc_b_q;

endmodule

// ----- rtl/core/lwc_ratio.sv -----
// Shared unit that turns one set of window sums into floor(255 * r^2).
// Multi-cycle: products, split wide squares, then bit-serial division. Depends on lwc_pkg.
module lwc_ratio (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lwc_pkg::lwc_job_t         job,
	output logic                      done,
	output logic [lwc_pkg::STR_W-1:0] result
);
	import lwc_pkg::*;

	lwc_rstate_t       state_q, state_d;
	logic [WIN_W-1:0]  n_q;
	lwc_sums_t         s_q;
	logic [VAR_W-1:0]  nsff_q, sfsf_q, nsgg_q, sgsg_q, nsfg_q, sfsg_q;
	logic [VAR_W-1:0]  cov_q, varf_q, varg_q;
	logic              zero_q;
	logic [1:0]        part_q;
	logic [PROD_W-1:0] num_acc_q, den_acc_q;
	logic [NUM_W-1:0]  rem_q;
	logic [2:0]        bit_q;
	logic [STR_W-1:0]  quo_q;
	logic [HALF_W-1:0] cov_op, varf_op, varg_op;
	logic [VAR_W-1:0]  cov_sq_part, den_part;
	logic [6:0]        shamt;
	logic [NUM_W-1:0]  trial;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			RS_IDLE:  if (job.start) state_d = RS_MUL;
			RS_MUL:   state_d = RS_SUB;
			RS_SUB:   state_d = RS_PART;
			RS_PART:  if (part_q == 2'd3) state_d = RS_SCALE;
			RS_SCALE: state_d = RS_DIV;
			RS_DIV:   if (bit_q == 3'd0) state_d = RS_DONE;
			RS_DONE: begin
				done    = 1'b1;
				state_d = RS_IDLE;
			end
			default:  state_d = RS_IDLE;
		endcase
	end

	// Partial products of the two 44-bit squares, one 22-bit half pair a cycle.
	always_comb begin
		cov_op  = part_q[1] ? cov_q[VAR_W-1:HALF_W]  : cov_q[HALF_W-1:0];
		varf_op = part_q[1] ? varf_q[VAR_W-1:HALF_W] : varf_q[HALF_W-1:0];
		varg_op = part_q[0] ? varg_q[VAR_W-1:HALF_W] : varg_q[HALF_W-1:0];
		cov_sq_part = {{HALF_W{1'b0}}, cov_op} *
			{{HALF_W{1'b0}}, (part_q[0] ? cov_q[VAR_W-1:HALF_W] : cov_q[HALF_W-1:0])};
		den_part = {{HALF_W{1'b0}}, varf_op} * {{HALF_W{1'b0}}, varg_op};
		shamt = 7'(({1'b0, part_q[1]} + {1'b0, part_q[0]}) * HALF_W);
		trial = {{STR_W{1'b0}}, den_acc_q} << bit_q;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			RS_IDLE: begin
				n_q <= job.n;
				s_q <= job.sums;
			end
			RS_MUL: begin
				nsff_q <= {{(VAR_W-WIN_W){1'b0}}, n_q} * {{(VAR_W-SQ_W){1'b0}}, s_q.sff};
				nsgg_q <= {{(VAR_W-WIN_W){1'b0}}, n_q} * {{(VAR_W-SQ_W){1'b0}}, s_q.sgg};
				nsfg_q <= {{(VAR_W-WIN_W){1'b0}}, n_q} * {{(VAR_W-SQ_W){1'b0}}, s_q.sfg};
				sfsf_q <= {{(VAR_W-SUM_W){1'b0}}, s_q.sf} * {{(VAR_W-SUM_W){1'b0}}, s_q.sf};
				sgsg_q <= {{(VAR_W-SUM_W){1'b0}}, s_q.sg} * {{(VAR_W-SUM_W){1'b0}}, s_q.sg};
				sfsg_q <= {{(VAR_W-SUM_W){1'b0}}, s_q.sf} * {{(VAR_W-SUM_W){1'b0}}, s_q.sg};
			end
			RS_SUB: begin
				varf_q    <= nsff_q - sfsf_q;
				varg_q    <= nsgg_q - sgsg_q;
				cov_q     <= (nsfg_q >= sfsg_q) ? nsfg_q - sfsg_q : sfsg_q - nsfg_q;
				zero_q    <= (nsff_q == sfsf_q) || (nsgg_q == sgsg_q);
				part_q    <= 2'd0;
				num_acc_q <= '0;
				den_acc_q <= '0;
			end
			RS_PART: begin
				num_acc_q <= num_acc_q + ({{VAR_W{1'b0}}, cov_sq_part} << shamt);
				den_acc_q <= den_acc_q + ({{VAR_W{1'b0}}, den_part} << shamt);
				part_q    <= part_q + 2'd1;
			end
			RS_SCALE: begin
				// Multiply by 255 as a shift and a subtract.
				rem_q <= {num_acc_q, {STR_W{1'b0}}} - {{STR_W{1'b0}}, num_acc_q};
				bit_q <= 3'd7;
				quo_q <= '0;
			end
			RS_DIV: begin
				if (trial <= rem_q) begin
					rem_q        <= rem_q - trial;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 3'd1;
			end
			default: begin
			end
		endcase
	end

	// Zero variance in either window gives zero strength.
	assign result = zero_q ? '0 : quo_q;

endmodule

// ----- rtl/core/lagged_window_correlation.sv -----
// Lagged window correlation: per item, writes one sample pair into ring histories and,
// once enough pairs are held, returns max_lag results (lag 0 upward).
// After an accepted item the history is streamed through the cell row and drained; then,
// per result, the shared ratio unit works out two sum sets in turn, and the result is
// loaded once the output register is free. A warm-up item gives no results. The
// block takes one item at a time. Reset clears the write pointer, fill count, config
// registers (window 40, lags 20) and control; history contents are not cleared.
module lagged_window_correlation #(
	parameter int HISTORY_DEPTH = lwc_pkg::HISTORY_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lwc_in_if.sink    in_ch,
	lwc_out_if.source out_ch,
	lwc_cfg_if.sink   cfg_ch
);
	import lwc_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	logic [SAMPLE_W-1:0] f_mem [HISTORY_DEPTH];
	logic [SAMPLE_W-1:0] g_mem [HISTORY_DEPTH];

	lwc_state_t          state_q, state_d;
	logic [WIN_W-1:0]    win_cfg_q, win_q, t_q;
	logic [LAGCFG_W-1:0] lag_cfg_q, lags_q, drain_q;
	logic [AW-1:0]       wp_q, rd_addr_q;
	logic [FILL_W-1:0]   fill_q, fill_next;
	logic [LAG_W-1:0]    lag_q;
	logic                issued_q;
	logic [STR_W-1:0]    str_a_q;
	logic [STR_W-1:0]    rresult_hold_q;
	lwc_tap_t            bcast_s1;
	logic                in_fire, emit_fire, warm;
	logic [WIN_W:0]      need;
	lwc_job_t            job;
	logic                rdone;
	logic [STR_W-1:0]    rresult;
	logic                out_valid_q, out_last_q;
	logic [LAG_W-1:0]    out_lag_q;
	logic [STR_W-1:0]    out_fs_q, out_gs_q;
	lwc_tap_t            chain [NUM_CELLS+1];
	lwc_sums_t           sums_a [NUM_CELLS];
	lwc_sums_t           sums_b [NUM_CELLS];

	// Configuration registers; users must have writes arrive only while the block is idle; the block does not check.
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q <= WIN_W'(WIN_RESET);
			lag_cfg_q <= LAGCFG_W'(LAG_RESET);
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				CFG_WINDOW_SIZE: win_cfg_q <= cfg_ch.data;
				CFG_MAX_LAG:     lag_cfg_q <= cfg_ch.data[LAGCFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign fill_next   = (fill_q == FILL_W'(FILL_MAX)) ? fill_q : fill_q + 1'b1;
	assign need        = {1'b0, clamp_win(win_cfg_q)} + (WIN_W+1)'(clamp_lag(lag_cfg_q));
	assign warm        = {1'b0, fill_next} >= (FILL_W+1)'(need);
	assign emit_fire   = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);

	// History write on each accepted item.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			f_mem[wp_q] <= in_ch.f_sample;
			g_mem[wp_q] <= in_ch.g_sample;
		end
	end

	// Registered history read, newest sample first, broadcast to all cells.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcast_s1.valid <= 1'b0;
		end else begin
			bcast_s1.valid <= (state_q == ST_STREAM);
			bcast_s1.idx   <= t_q;
			bcast_s1.f     <= f_mem[rd_addr_q];
			bcast_s1.g     <= g_mem[rd_addr_q];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and ratio requests.
	always_comb begin
		state_d   = state_q;
		job.start = 1'b0;
		job.n     = win_q;
		job.sums  = (state_q == ST_CALC_B) ? sums_b[lag_q] : sums_a[lag_q];
		unique case (state_q)
			ST_IDLE:   if (in_fire && warm) state_d = ST_STREAM;
			ST_STREAM: if (t_q == WIN_W'({1'b0, win_q} + (WIN_W+1)'(lags_q) - 2'd2))
				state_d = ST_DRAIN;
			ST_DRAIN:  if (drain_q == lags_q + 2'd2) state_d = ST_CALC_A;
			ST_CALC_A: begin
				job.start = !issued_q;
				if (rdone) state_d = ST_CALC_B;
			end
			ST_CALC_B: begin
				job.start = !issued_q;
				if (rdone) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire)
					state_d = ({1'b0, lag_q} == lags_q - 1'b1) ? ST_IDLE : ST_CALC_A;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer counters and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			issued_q <= 1'b0;
			lag_q    <= '0;
		end else begin
			if (in_fire) begin
				wp_q   <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				fill_q <= fill_next;
			end
			if (job.start) issued_q <= 1'b1;
			else if (rdone) issued_q <= 1'b0;
			if (state_q == ST_DRAIN) lag_q <= '0;
			else if (emit_fire) lag_q <= lag_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			win_q     <= clamp_win(win_cfg_q);
			lags_q    <= clamp_lag(lag_cfg_q);
			rd_addr_q <= wp_q;
			t_q       <= '0;
			drain_q   <= '0;
		end
		if (state_q == ST_STREAM) begin
			rd_addr_q <= (rd_addr_q == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_q - 1'b1;
			t_q       <= t_q + 1'b1;
		end
		if (state_q == ST_DRAIN) drain_q <= drain_q + 1'b1;
		if (state_q == ST_CALC_A && rdone) str_a_q <= rresult;
	end

	// Row of lag cells; cell k sees the stream after k delay registers.
	assign chain[0] = bcast_s1;
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		lwc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clr       (in_fire),
			.win       (win_q),
			.bcast     (bcast_s1),
			.chain_in  (chain[k]),
			.chain_out (chain[k+1]),
			.sums_a    (sums_a[k]),
			.sums_b    (sums_b[k])
		);
	end

	lwc_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.done   (rdone),
		.result (rresult)
	);

	// Output register for one result item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_lag_q  <= lag_q;
			out_fs_q   <= str_a_q;
			out_gs_q   <= rresult_hold_q;
			out_last_q <= ({1'b0, lag_q} == lags_q - 1'b1);
		end
	end

	// Second strength is held until the result item is loaded.
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC_B && rdone) rresult_hold_q <= rresult;
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.lag                = out_lag_q;
	assign out_ch.f_delayed_strength = out_fs_q;
	assign out_ch.g_delayed_strength = out_gs_q;
	assign out_ch.last               = out_last_q;

endmodule
